// File: hw/rtl/swac_pkg.sv
// Shared constants, codes and controller/datapath interface types of the anagram counter.
`default_nettype none

package swac_pkg;

  // Longest pattern the window can hold.
  localparam int MAX_PATTERN = 64;

  // Ring pointer, length and count widths follow from the pattern limit.
  localparam int PTR_W   = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
  localparam int LEN_W   = $clog2(MAX_PATTERN + 1);
  localparam int CNT_W   = $clog2(MAX_PATTERN + 1) + 1;
  localparam int UNMET_W = 9;
  localparam int TOTAL_W = 16;
  localparam int BYTE_W  = 8;
  localparam int REQ_W   = 2;
  localparam int STAT_W  = 2;
  localparam int NUM_VALUES = 256;

  // Request kinds.
  localparam logic [REQ_W-1:0] REQ_CLEAR   = 2'd0;
  localparam logic [REQ_W-1:0] REQ_PATTERN = 2'd1;
  localparam logic [REQ_W-1:0] REQ_TEXT    = 2'd2;

  // Result status codes.
  localparam logic [STAT_W-1:0] ST_OK         = 2'd0;
  localparam logic [STAT_W-1:0] ST_TOO_LONG   = 2'd1;
  localparam logic [STAT_W-1:0] ST_NO_PATTERN = 2'd2;
  localparam logic [STAT_W-1:0] ST_AFTER_TEXT = 2'd3;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;    // latch the input word
    logic decode;    // classify, clear, issue first reads
    logic pat_wr;    // write back a pattern count
    logic give_rd;   // read the count of the byte leaving the window
    logic give_wr;   // write back the leaving byte's count
    logic take_rd;   // read the count of the entering byte
    logic take_wr;   // write back the entering byte's count, move the window
    logic load_out;  // move the result into the output register
  } swac_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [REQ_W-1:0]  req;       // latched request kind
    logic [STAT_W-1:0] dec_code;  // status the current request will answer
    logic              win_full;  // window already holds a whole pattern length
    logic              out_free;  // output register can take a new word
  } swac_stat_t;

endpackage

`default_nettype wire

// File: hw/rtl/swac_ctrl.sv
// Sequencing state machine of the anagram counter.
`default_nettype none

module swac_ctrl (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_tvalid,
  output logic                     in_tready,
  input  wire swac_pkg::swac_stat_t stat,
  output swac_pkg::swac_cmd_t      cmd
);

  typedef enum logic [7:0] {
    S_IDLE    = 8'b0000_0001,
    S_DECODE  = 8'b0000_0010,
    S_PAT_WR  = 8'b0000_0100,
    S_GIVE_RD = 8'b0000_1000,
    S_GIVE_WR = 8'b0001_0000,
    S_TAKE_RD = 8'b0010_0000,
    S_TAKE_WR = 8'b0100_0000,
    S_RESP    = 8'b1000_0000
  } state_t;

  state_t state_r, state_nxt;

  assign in_tready = (state_r == S_IDLE);

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) state_nxt = S_DECODE;
      end
      S_DECODE: begin
        priority if (stat.dec_code != swac_pkg::ST_OK) begin
          state_nxt = S_RESP;
        end else if (stat.req == swac_pkg::REQ_PATTERN) begin
          state_nxt = S_PAT_WR;
        end else if (stat.req == swac_pkg::REQ_TEXT) begin
          state_nxt = stat.win_full ? S_GIVE_RD : S_TAKE_RD;
        end else begin
          state_nxt = S_RESP;
        end
      end
      S_PAT_WR:  state_nxt = S_RESP;
      S_GIVE_RD: state_nxt = S_GIVE_WR;
      S_GIVE_WR: state_nxt = S_TAKE_RD;
      S_TAKE_RD: state_nxt = S_TAKE_WR;
      S_TAKE_WR: state_nxt = S_RESP;
      S_RESP: begin
        if (stat.out_free) state_nxt = S_IDLE;
      end
      default:   state_nxt = S_IDLE;
    endcase
  end

  // Commands decoded from the current state.
  always_comb begin
    cmd          = '0;
    cmd.accept   = (state_r == S_IDLE) && in_tvalid;
    cmd.decode   = (state_r == S_DECODE);
    cmd.pat_wr   = (state_r == S_PAT_WR);
    cmd.give_rd  = (state_r == S_GIVE_RD);
    cmd.give_wr  = (state_r == S_GIVE_WR);
    cmd.take_rd  = (state_r == S_TAKE_RD);
    cmd.take_wr  = (state_r == S_TAKE_WR);
    cmd.load_out = (state_r == S_RESP) && stat.out_free;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/swac_dp.sv
// Datapath of the anagram counter: count memory, window ring, counters, output register.
`default_nettype none

module swac_dp (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic [swac_pkg::REQ_W-1:0]    in_req,
  input  wire logic [swac_pkg::BYTE_W-1:0]   in_byte,
  input  wire swac_pkg::swac_cmd_t           cmd,
  output swac_pkg::swac_stat_t               stat,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic                               out_match,
  output logic [swac_pkg::TOTAL_W-1:0]       out_total,
  output logic [swac_pkg::STAT_W-1:0]        out_status
);

  localparam int CW = swac_pkg::CNT_W;
  localparam int LW = swac_pkg::LEN_W;
  localparam int PW = swac_pkg::PTR_W;
  localparam int UW = swac_pkg::UNMET_W;
  localparam int TW = swac_pkg::TOTAL_W;
  localparam int BW = swac_pkg::BYTE_W;

  // Latched request.
  logic [swac_pkg::REQ_W-1:0] req_r;
  logic [BW-1:0]              byte_r;

  // Job state.
  logic [LW-1:0] pat_len_r, pat_len_nxt;
  logic [UW-1:0] unmet_r, unmet_nxt;
  logic [LW-1:0] filled_r, filled_nxt;
  logic [PW-1:0] ring_r, ring_nxt;
  logic [TW-1:0] total_r, total_nxt;
  logic          begun_r, begun_nxt;
  logic          match_r, match_nxt;
  logic [swac_pkg::STAT_W-1:0] status_r, dec_code;

  // Count memory entry: pattern flag on top of a signed need count.
  logic [CW:0]                        cnt_mem [swac_pkg::NUM_VALUES];
  logic [swac_pkg::NUM_VALUES-1:0]    vld_r;
  logic [CW:0]                        cnt_q;
  logic                               vld_q;
  logic [BW-1:0]                      cnt_addr;
  logic                               cnt_re, cnt_we;
  logic [CW:0]                        cnt_wdata;
  logic [CW:0]                        ent;
  logic signed [CW-1:0]               cur_cnt;
  logic                               cur_in;

  // Window ring of the last text bytes.
  logic [BW-1:0] win_mem [swac_pkg::MAX_PATTERN];
  logic [BW-1:0] win_q;

  logic          is_clear;
  logic          len_full;
  logic          win_full;
  logic [LW-1:0] pos_inc;
  logic          out_valid_r;

  assign is_clear = cmd.decode && (req_r == swac_pkg::REQ_CLEAR);
  assign len_full = (pat_len_r == LW'(swac_pkg::MAX_PATTERN));
  assign win_full = (filled_r >= pat_len_r);

  // Status the latched request will answer.
  always_comb begin
    dec_code = swac_pkg::ST_OK;
    if (req_r == swac_pkg::REQ_PATTERN) begin
      priority if (begun_r) dec_code = swac_pkg::ST_AFTER_TEXT;
      else if (len_full)    dec_code = swac_pkg::ST_TOO_LONG;
    end else if (req_r == swac_pkg::REQ_TEXT) begin
      if (pat_len_r == '0) dec_code = swac_pkg::ST_NO_PATTERN;
    end
  end

  assign stat.req      = req_r;
  assign stat.dec_code = dec_code;
  assign stat.win_full = win_full;
  assign stat.out_free = !out_valid_r || out_ready;

  // An entry never written since the last clear reads as zero, not in pattern.
  assign ent     = vld_q ? cnt_q : '0;
  assign cur_cnt = ent[CW-1:0];
  assign cur_in  = ent[CW];

  assign cnt_addr = (cmd.give_rd || cmd.give_wr) ? win_q : byte_r;
  assign cnt_re   = cmd.decode || cmd.give_rd || cmd.take_rd;
  assign cnt_we   = cmd.pat_wr || cmd.give_wr || cmd.take_wr;

  // Count write data and bookkeeping of the next values.
  always_comb begin
    cnt_wdata   = ent;
    pat_len_nxt = pat_len_r;
    unmet_nxt   = unmet_r;
    filled_nxt  = filled_r;
    ring_nxt    = ring_r;
    total_nxt   = total_r;
    begun_nxt   = begun_r;
    match_nxt   = match_r;
    pos_inc     = LW'(ring_r) + LW'(1);
    priority if (is_clear) begin
      pat_len_nxt = '0;
      unmet_nxt   = '0;
      filled_nxt  = '0;
      ring_nxt    = '0;
      total_nxt   = '0;
      begun_nxt   = 1'b0;
      match_nxt   = 1'b0;
    end else if (cmd.decode) begin
      match_nxt = 1'b0;
      if (req_r == swac_pkg::REQ_TEXT && dec_code == swac_pkg::ST_OK) begin
        begun_nxt = 1'b1;
      end
    end else if (cmd.pat_wr) begin
      // Pattern byte raises its need and may add a distinct value.
      cnt_wdata   = {1'b1, CW'(cur_cnt + CW'(1))};
      pat_len_nxt = pat_len_r + LW'(1);
      if (!cur_in) unmet_nxt = unmet_r + UW'(1);
    end else if (cmd.give_wr) begin
      // Leaving byte raises its need.
      if (cur_in) begin
        cnt_wdata = {1'b1, CW'(cur_cnt + CW'(1))};
        if (cur_cnt == '0) unmet_nxt = unmet_r + UW'(1);
      end
    end else if (cmd.take_wr) begin
      // Entering byte lowers its need, then the window advances.
      if (cur_in) begin
        cnt_wdata = {1'b1, CW'(cur_cnt - CW'(1))};
        if (cur_cnt == CW'(1)) unmet_nxt = unmet_r - UW'(1);
      end
      if (!win_full) filled_nxt = filled_r + LW'(1);
      ring_nxt = (pos_inc >= pat_len_r) ? '0 : PW'(pos_inc);
      if ((filled_nxt >= pat_len_r) && (unmet_nxt == '0)) begin
        match_nxt = 1'b1;
        if (total_r != '1) total_nxt = total_r + TW'(1);
      end
    end
  end

  // Input latch.
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      req_r  <= in_req;
      byte_r <= in_byte;
    end
  end

  // Count memory with registered read.
  always_ff @(posedge clk) begin
    if (cnt_we) cnt_mem[cnt_addr] <= cnt_wdata;
    if (cnt_re) cnt_q <= cnt_mem[cnt_addr];
  end

  always_ff @(posedge clk) begin
    if (cnt_re) vld_q <= vld_r[cnt_addr];
  end

  // Entry valid bits, cleared at once by reset and by a clear request.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (is_clear) begin
      vld_r <= '0;
    end else if (cnt_we) begin
      vld_r[cnt_addr] <= 1'b1;
    end
  end

  // Window ring: oldest byte is read at decode, new byte written at the end.
  always_ff @(posedge clk) begin
    if (cmd.take_wr) win_mem[ring_r] <= byte_r;
    if (cmd.decode) win_q <= win_mem[ring_r];
  end

  // Job state and result registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pat_len_r <= '0;
      unmet_r   <= '0;
      filled_r  <= '0;
      ring_r    <= '0;
      total_r   <= '0;
      begun_r   <= 1'b0;
      match_r   <= 1'b0;
    end else begin
      pat_len_r <= pat_len_nxt;
      unmet_r   <= unmet_nxt;
      filled_r  <= filled_nxt;
      ring_r    <= ring_nxt;
      total_r   <= total_nxt;
      begun_r   <= begun_nxt;
      match_r   <= match_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.decode) status_r <= dec_code;
  end

  // Output register: holds one result word until the receiver takes it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_match  <= match_r;
      out_total  <= total_r;
      out_status <= status_r;
    end
  end

  assign out_valid = out_valid_r;

endmodule

`default_nettype wire

// File: hw/rtl/sliding_window_anagram_counter_top.sv
// Top level of the sliding-window anagram counter.
//
// Input words arrive on the in_ stream: in_tuser carries the request kind
// (clear, pattern byte, text byte) and in_tdata the byte. Every input word
// produces exactly one result word on the out_ stream, in order, carrying
// the match flag, the saturating match total and a status code.
// One word is processed at a time. After acceptance a word is decoded and
// then answered (clear, rejected or unused requests); a pattern byte first
// writes back its count, and a text byte reads and writes back the count of
// the entering byte, preceded once the window is full by the same for the
// leaving byte. The next word is accepted only after the result step. The
// single-port count memory forces these separate read and write-back steps.
// A result sits in an output register, so the next word is accepted while
// the previous result still waits. If the receiver stalls, the following
// word completes and then waits until the output register frees up.
// Reset (rst_n low, synchronous) empties both channels and clears all job
// state; count entries are marked invalid at once, so no clearing pass is
// needed and the block is ready to accept a word as soon as reset ends.
`default_nettype none

module sliding_window_anagram_counter_top (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // [7:0] byte_value
  input  wire logic [1:0]  in_tuser,   // [1:0] req_type
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [23:0]      out_tdata,  // [0] is_match, [16:1] match_total, [23:17] zero
  output logic [1:0]       out_tuser   // [1:0] status
);

  swac_pkg::swac_cmd_t  cmd;
  swac_pkg::swac_stat_t stat;
  logic                 out_match;
  logic [15:0]          out_total;

  swac_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  swac_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_req     (in_tuser),
    .in_byte    (in_tdata),
    .cmd        (cmd),
    .stat       (stat),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_match  (out_match),
    .out_total  (out_total),
    .out_status (out_tuser)
  );

  assign out_tdata = {7'b0, out_total, out_match};

endmodule

`default_nettype wire

// File: test/tb_top.sv
// Self-checking testbench for the sliding-window anagram counter.
`timescale 1ns / 1ps

module tb_top;

  // Request kind that the block answers without changing its counts or pattern.
  localparam logic [swac_pkg::REQ_W-1:0] REQ_UNUSED = 2'd3;

  localparam int RANDOM_WORDS  = 1200;
  localparam int TAIL_TEXT     = 24;
  localparam int HOLD_OFF      = 400;
  localparam int STALL_LIMIT   = 2000;
  localparam int TOTAL_MAX     = 65535;

  // One input word and one result word as the block sees them.
  typedef struct packed {
    logic [swac_pkg::REQ_W-1:0]  kind;
    logic [swac_pkg::BYTE_W-1:0] value;
  } word_t;

  typedef struct packed {
    logic                         hit;
    logic [swac_pkg::TOTAL_W-1:0] total;
    logic [swac_pkg::STAT_W-1:0]  status;
  } tally_t;

  logic              clk;
  logic              rst_n      = 1'b0;
  logic              in_tvalid  = 1'b0;
  logic [7:0]        in_tdata   = 8'd0;
  logic [1:0]        in_tuser   = 2'd0;
  logic              out_tready = 1'b0;
  logic              in_tready;
  logic              out_tvalid;
  logic [23:0]       out_tdata;
  logic [1:0]        out_tuser;

  word_t  word_queue[$];
  tally_t tally_queue[$];

  // Handshake flags and counters shared between the driver, receiver and monitor.
  logic in_fire       = 1'b0;
  bit   failed        = 1'b0;
  bit   pressure_done = 1'b0;
  int   cycle_count   = 0;
  int   idle_cycles   = 0;
  int   words_sent    = 0;
  int   results_seen  = 0;
  int   words_queued  = 0;
  int   quiet_start   = 0;
  int   send_gap      = 0;
  int   hold_left     = 0;
  word_t next_word;

  // Mirror of the job state of the counter.
  int          need_by_value [swac_pkg::NUM_VALUES];
  bit          value_in_pattern [swac_pkg::NUM_VALUES];
  logic [7:0]  window_ring [swac_pkg::MAX_PATTERN];
  int          pat_len;
  int          unmet;
  int          fill;
  int          ring_pos;
  int          match_count;
  bit          text_seen;

  wire noisy_period = (cycle_count % 900) >= 300;

  sliding_window_anagram_counter_top u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),   // [7:0] byte_value
    .in_tuser   (in_tuser),   // [1:0] req_type
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),  // [0] is_match, [16:1] match_total, [23:17] zero
    .out_tuser  (out_tuser)   // [1:0] status
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Return the job state to its cleared values.
  function automatic void clear_job();
    for (int v = 0; v < swac_pkg::NUM_VALUES; v++) begin
      need_by_value[v]    = 0;
      value_in_pattern[v] = 1'b0;
    end
    pat_len     = 0;
    unmet       = 0;
    fill        = 0;
    ring_pos    = 0;
    match_count = 0;
    text_seen   = 1'b0;
  endfunction

  // Apply one accepted word to the job state and return the result it causes.
  function automatic tally_t predict_tally(input word_t w);
    tally_t     r;
    logic [7:0] old;
    r.hit    = 1'b0;
    r.status = swac_pkg::ST_OK;
    case (w.kind)
      swac_pkg::REQ_CLEAR: begin
        clear_job();
      end
      swac_pkg::REQ_PATTERN: begin
        if (text_seen) begin
          r.status = swac_pkg::ST_AFTER_TEXT;
        end else if (pat_len >= swac_pkg::MAX_PATTERN) begin
          r.status = swac_pkg::ST_TOO_LONG;
        end else begin
          if (!value_in_pattern[w.value]) begin
            value_in_pattern[w.value] = 1'b1;
            unmet++;
          end
          need_by_value[w.value]++;
          pat_len++;
        end
      end
      swac_pkg::REQ_TEXT: begin
        if (pat_len == 0) begin
          r.status = swac_pkg::ST_NO_PATTERN;
        end else begin
          text_seen = 1'b1;
          // The oldest byte leaves once the window is full.
          if (fill >= pat_len) begin
            old = window_ring[ring_pos];
            if (value_in_pattern[old]) begin
              if (need_by_value[old] == 0) unmet++;
              need_by_value[old]++;
            end
          end else begin
            fill++;
          end
          if (value_in_pattern[w.value]) begin
            if (need_by_value[w.value] == 1) unmet--;
            need_by_value[w.value]--;
          end
          window_ring[ring_pos] = w.value;
          ring_pos = (ring_pos + 1 >= pat_len) ? 0 : ring_pos + 1;
          if (fill >= pat_len && unmet == 0) begin
            r.hit = 1'b1;
            if (match_count < TOTAL_MAX) match_count++;
          end
        end
      end
      default: ;
    endcase
    r.total = match_count[swac_pkg::TOTAL_W-1:0];
    return r;
  endfunction

  task automatic push_word(input logic [swac_pkg::REQ_W-1:0] kind,
                           input logic [swac_pkg::BYTE_W-1:0] value);
    word_t w;
    w.kind  = kind;
    w.value = value;
    word_queue.insert(word_queue.size(), w);
    words_queued++;
  endtask

  // Driver: offers the next word at the falling edge, with random gaps.
  always @(negedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || in_fire) begin
      if (send_gap > 0) begin
        send_gap--;
        in_tvalid <= 1'b0;
      end else if (noisy_period && words_sent < quiet_start && $urandom_range(0, 5) == 0) begin
        send_gap = $urandom_range(0, 7);
        in_tvalid <= 1'b0;
      end else if (word_queue.size() > 0) begin
        next_word = word_queue.pop_front();
        in_tuser  <= next_word.kind;
        in_tdata  <= next_word.value;
        in_tvalid <= 1'b1;
        words_sent++;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // Receiver: random stalls plus one long hold-off that backs up the input.
  always @(negedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (!pressure_done && results_seen >= 150) begin
      pressure_done = 1'b1;
      hold_left = HOLD_OFF - 1;
      out_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else if (noisy_period && results_seen < quiet_start && $urandom_range(0, 5) == 0) begin
      hold_left = $urandom_range(0, 7);
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  // Monitor: checks each result word, then predicts for each accepted input word.
  always @(posedge clk) begin
    tally_t got;
    tally_t want;
    word_t  taken;
    bit     out_fire;
    out_fire = rst_n && out_tvalid && out_tready;
    cycle_count <= cycle_count + 1;
    in_fire <= rst_n && in_tvalid && in_tready;

    if (out_fire) begin
      got.hit    = out_tdata[0];
      got.total  = out_tdata[16:1];
      got.status = out_tuser;
      results_seen <= results_seen + 1;
      if (tally_queue.size() == 0) begin
        $error("unexpected result word: is_match %0d, match_total %0d, status %0d",
               got.hit, got.total, got.status);
        failed = 1'b1;
      end else begin
        want = tally_queue.pop_front();
        if (got.hit !== want.hit) begin
          $error("is_match: expected %0d, actual %0d", want.hit, got.hit);
          failed = 1'b1;
        end
        if (got.total !== want.total) begin
          $error("match_total: expected %0d, actual %0d", want.total, got.total);
          failed = 1'b1;
        end
        if (got.status !== want.status) begin
          $error("status: expected %0d, actual %0d", want.status, got.status);
          failed = 1'b1;
        end
      end
    end

    if (rst_n && in_tvalid && in_tready) begin
      taken.kind  = in_tuser;
      taken.value = in_tdata;
      tally_queue.insert(tally_queue.size(), predict_tally(taken));
    end

    // Watchdog on cycles with no word moving on either side.
    if (out_fire || (rst_n && in_tvalid && in_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("tb_top: FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Stimulus, reset and end of run.
  initial begin
    logic [7:0] pat [swac_pkg::MAX_PATTERN];
    logic [7:0] perm [swac_pkg::MAX_PATTERN];
    logic [7:0] base;
    logic [7:0] tmp;
    int         plen;
    int         sel;
    int         ntext;
    int         extra;
    int         j;
    int         r2;
    bit         narrow;
    clear_job();

    // Directed words: unused kind, text without pattern, byte extremes,
    // repeated pattern bytes, matches, pattern after text and a clear.
    push_word(REQ_UNUSED, 8'h00);
    push_word(swac_pkg::REQ_TEXT, 8'h11);
    push_word(swac_pkg::REQ_CLEAR, 8'hFF);
    push_word(swac_pkg::REQ_PATTERN, 8'h00);
    push_word(swac_pkg::REQ_PATTERN, 8'hFF);
    push_word(swac_pkg::REQ_PATTERN, 8'h00);
    push_word(swac_pkg::REQ_TEXT, 8'hFF);
    push_word(swac_pkg::REQ_TEXT, 8'h00);
    push_word(swac_pkg::REQ_TEXT, 8'h00);
    push_word(swac_pkg::REQ_TEXT, 8'hFF);
    push_word(swac_pkg::REQ_TEXT, 8'h80);
    push_word(swac_pkg::REQ_PATTERN, 8'h33);
    push_word(REQ_UNUSED, 8'hAA);
    push_word(swac_pkg::REQ_CLEAR, 8'h00);
    push_word(swac_pkg::REQ_TEXT, 8'h00);

    // Random jobs: mostly clear, pattern, then text drawn from the pattern.
    while (words_queued < 15 + RANDOM_WORDS) begin
      if ($urandom_range(0, 99) < 8) begin
        // Noise: any kind of word in any order.
        repeat ($urandom_range(1, 8))
          push_word(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
      end else begin
        push_word(swac_pkg::REQ_CLEAR, 8'($urandom_range(0, 255)));
        sel  = $urandom_range(0, 9);
        plen = (sel < 7) ? $urandom_range(1, 6) :
               (sel < 9) ? $urandom_range(7, 32) : swac_pkg::MAX_PATTERN;
        narrow = $urandom_range(0, 1);
        base   = 8'($urandom_range(0, 255));
        for (int i = 0; i < plen; i++) begin
          pat[i] = narrow ? base + 8'($urandom_range(0, 3)) : 8'($urandom_range(0, 255));
          push_word(swac_pkg::REQ_PATTERN, pat[i]);
        end
        // A full-length pattern is followed by bytes that no longer fit.
        if (plen == swac_pkg::MAX_PATTERN) begin
          extra = $urandom_range(1, 3);
          repeat (extra) push_word(swac_pkg::REQ_PATTERN, 8'($urandom_range(0, 255)));
        end
        // Often start the text with a shuffled copy of the pattern.
        if ($urandom_range(0, 9) < 3) begin
          for (int i = 0; i < plen; i++) perm[i] = pat[i];
          for (int i = plen - 1; i > 0; i--) begin
            j = $urandom_range(0, i);
            tmp = perm[i];
            perm[i] = perm[j];
            perm[j] = tmp;
          end
          for (int i = 0; i < plen; i++) push_word(swac_pkg::REQ_TEXT, perm[i]);
        end
        ntext = plen + $urandom_range(1, (plen <= 8) ? 30 : 20);
        for (int i = 0; i < ntext; i++) begin
          r2 = $urandom_range(0, 99);
          if (r2 < 3)
            push_word(swac_pkg::REQ_PATTERN, 8'($urandom_range(0, 255)));
          else if (r2 < 6)
            push_word(REQ_UNUSED, 8'($urandom_range(0, 255)));
          else if (r2 < 80)
            push_word(swac_pkg::REQ_TEXT, pat[$urandom_range(0, plen - 1)]);
          else
            push_word(swac_pkg::REQ_TEXT, 8'($urandom_range(0, 255)));
        end
      end
    end

    // No idling for the last 40 random words and after; the last job runs at full speed.
    quiet_start = word_queue.size() - 40;
    push_word(swac_pkg::REQ_CLEAR, 8'h00);
    push_word(swac_pkg::REQ_PATTERN, 8'h42);
    repeat (TAIL_TEXT) push_word(swac_pkg::REQ_TEXT, 8'h42);
    push_word(REQ_UNUSED, 8'h42);
    push_word(swac_pkg::REQ_PATTERN, 8'h42);
    push_word(swac_pkg::REQ_CLEAR, 8'h00);

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Wait for the last word to go in and every result to come out.
    @(posedge clk);
    while (word_queue.size() > 0 || in_tvalid) @(posedge clk);
    while (tally_queue.size() > 0) @(posedge clk);
    repeat (20) @(posedge clk);

    if (failed) begin
      $display("tb_top: FAIL");
    end else begin
      $display("tb_top: PASS");
    end
    $finish;
  end

endmodule

// File: filelist.f
hw/rtl/swac_pkg.sv
hw/rtl/swac_ctrl.sv
hw/rtl/swac_dp.sv
hw/rtl/sliding_window_anagram_counter_top.sv
test/tb_top.sv
